/* hdl/lazy_range_flip_count_tree_macros.svh */
// assertion macros shared by the tree block
`ifndef LAZY_RANGE_FLIP_COUNT_TREE_MACROS_SVH
`define LAZY_RANGE_FLIP_COUNT_TREE_MACROS_SVH
// implication checked on every clock edge outside reset
`define LRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hdl/lrt_pkg.sv */
// package: tags, operation codes and controller commands for the tree block
package lrt_pkg;
    localparam int OP_W = 3;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_SET = 3'd1,
        OP_CLR = 3'd2,
        OP_INV = 3'd3,
        OP_COUNT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_INV = 2'd1,
        TAG_CLR = 2'd2,
        TAG_SET = 2'd3
    } tag_t;

    // datapath command phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PUSH = 3'd1,
        PH_LOAD = 3'd2,
        PH_WALK = 3'd3,
        PH_FIX = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    typedef struct packed {
        logic start;
        phase_t phase;
        logic sel_hi;
    } dp_cmd_t;

    // clearing: memories still being zeroed after reset
    typedef struct packed {
        logic step_done;
        logic skip;
        logic is_count;
        logic is_load;
        logic clearing;
    } dp_stat_t;

    // tag composition: clear or set replaces, invert flips none/invert and clear/set
    function automatic tag_t tag_compose(tag_t old_t, tag_t nw);
        tag_t res;
        res = old_t;
        if (nw == TAG_CLR || nw == TAG_SET) res = nw;
        else if (nw == TAG_INV) res = tag_t'(old_t ^ 2'd1);
        return res;
    endfunction
endpackage

/* hdl/lazy_range_flip_count_tree.sv */
// top level: stream wrapper joining the tree controller and datapath
// Range set/clear/invert/count and single-bit load over a LEAVES-bit row kept as a lazy
// segment tree in on-chip memories. One request is handled at a time, paced by the one
// write port on each node memory. An update runs two push-downs (first and last leaf),
// a range walk and two path rebuilds; a count runs the two push-downs and the range
// walk, then waits on m_tready; a load runs one push-down, the leaf write and one
// rebuild. A request that does nothing leaves from the first push-down state, a count
// still giving a zero result. After reset a clearing pass zeroes the node memories
// before the first request is taken. Only a count gives a result.
module lazy_range_flip_count_tree
    import lrt_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[2:0], first_index[12:3],
                                   // last_index[22:13], leaf_bit[23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ones_count[10:0]
);
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic busy;
    logic [CNT_W-1:0] cnt;

    assign s_tready = !busy;

    lrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_accept(s_tvalid && s_tready),
        .result_accept(m_tvalid && m_tready),
        .stat(stat), .cmd(cmd), .busy(busy), .result_valid(m_tvalid)
    );

    lrt_dp #(.LEAVES(LEAVES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .operation(s_tdata[2:0]), .first_index(s_tdata[12:3]),
        .last_index(s_tdata[22:13]), .leaf_bit(s_tdata[23]),
        .stat(stat), .ones_count(cnt)
    );

    assign m_tdata = {5'd0, cnt};
endmodule

/* hdl/lrt_ctrl.sv */
// controller: sequences push-down, load, range walk and path rebuild phases
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_accept,
    input  logic     result_accept,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     result_valid
);
`include "lazy_range_flip_count_tree_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PUSH_LO = 8'b0000_0010,
        S_PUSH_HI = 8'b0000_0100,
        S_LOAD = 8'b0000_1000,
        S_WALK = 8'b0001_0000,
        S_FIX_LO = 8'b0010_0000,
        S_FIX_HI = 8'b0100_0000,
        S_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept) state_next = S_PUSH_LO;
            end
            S_PUSH_LO:
            begin
                if (stat.skip) state_next = stat.is_count ? S_OUT : S_IDLE;
                else if (stat.step_done) state_next = stat.is_load ? S_LOAD : S_PUSH_HI;
            end
            S_PUSH_HI:
            begin
                if (stat.step_done) state_next = S_WALK;
            end
            S_LOAD:
            begin
                state_next = S_FIX_LO;
            end
            S_WALK:
            begin
                if (stat.step_done) state_next = stat.is_count ? S_OUT : S_FIX_LO;
            end
            S_FIX_LO:
            begin
                if (stat.step_done) state_next = stat.is_load ? S_IDLE : S_FIX_HI;
            end
            S_FIX_HI:
            begin
                if (stat.step_done) state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (result_accept) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // command decode
    always_comb
    begin
        cmd.start = (state_reg == S_IDLE) && req_accept;
        cmd.sel_hi = 1'b0;
        unique case (state_reg)
            S_PUSH_LO: cmd.phase = PH_PUSH;
            S_PUSH_HI:
            begin
                cmd.phase = PH_PUSH;
                cmd.sel_hi = 1'b1;
            end
            S_LOAD: cmd.phase = PH_LOAD;
            S_WALK: cmd.phase = PH_WALK;
            S_FIX_LO: cmd.phase = PH_FIX;
            S_FIX_HI:
            begin
                cmd.phase = PH_FIX;
                cmd.sel_hi = 1'b1;
            end
            S_OUT: cmd.phase = PH_DONE;
            default: cmd.phase = PH_IDLE;
        endcase
    end

    // no request is taken while the memories are being cleared
    assign busy = (state_reg != S_IDLE) || stat.clearing;
    assign result_valid = (state_reg == S_OUT);

    `LRT_ASSERT_IMP(a_onehot_state, 1'b1, $onehot(state_reg), "state not one-hot")
    `LRT_ASSERT_NEXT(a_out_holds, result_valid && !result_accept, result_valid,
        "result dropped before taken")
    `LRT_ASSERT_NEXT(a_start_leaves_idle, cmd.start, busy, "request not taken up")
endmodule

/* hdl/lrt_dp.sv */
// datapath: node count and tag memories with a walker that writes each memory at most once a step
module lrt_dp
    import lrt_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [OP_W-1:0]  operation,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] last_index,
    input  logic             leaf_bit,
    output dp_stat_t         stat,
    output logic [CNT_W-1:0] ones_count
);
    localparam int LEV = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
    localparam int SPAN = 1 << LEV;
    localparam int NW = LEV + 1;          // node address bits
    localparam int OW = LEV + 1;          // node count width
    localparam int LVW = $clog2(LEV + 1);
    localparam int SUMW = (OW > CNT_W) ? OW : CNT_W;
    localparam int AW = (IDX_W > NW) ? IDX_W : NW;

    // node memories; a clearing pass zeroes them after reset
    logic [OW-1:0] ones_mem [2*SPAN];
    tag_t tag_mem [SPAN];

    // micro-step: each node handled as read (registered) then write
    logic [NW-1:0] clr_reg, clr_next;
    logic clearing_reg, clearing_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [NW-1:0] l_reg, l_next, r_reg, r_next;
    logic [LVW-1:0] h_reg, h_next;
    logic [1:0] sub_reg, sub_next;
    logic bit_reg, bit_next;
    logic skip_reg, skip_next;
    logic [SUMW-1:0] total_reg, total_next;
    tag_t ptag_reg, ptag_next;

    // memory read data
    logic [OW-1:0] rd_a, rd_b;
    tag_t rd_tag;
    logic [NW-1:0] ra_a, ra_b;
    logic [NW-2:0] ra_t;
    logic we_o;
    logic [NW-1:0] wa_o;
    logic [OW-1:0] wd_o;
    logic we_t;
    logic [NW-2:0] wa_t;
    tag_t wd_t;
    logic done_c;
    logic lvl_step;

    logic [AW-1:0] a_ext, b_ext, b_cl;
    tag_t op_tag;
    logic cnt_op;
    logic [NW-1:0] cur_leaf, cur_node;
    logic [NW-1:0] kid_lo, kid_hi;
    logic [NW-1:0] lo_start, hi_start;
    logic [NW:0] l_up;
    logic [NW-1:0] r_dn;

    assign a_ext = AW'(first_index);
    assign b_ext = (AW'(last_index) > AW'(LEAVES - 1)) ? AW'(LEAVES - 1) : AW'(last_index);
    assign b_cl = b_ext;
    assign lo_start = NW'(SPAN) + NW'(a_ext);
    assign hi_start = NW'(SPAN) + NW'(b_cl);
    assign cnt_op = (op_reg == OP_W'(OP_COUNT));

    always_comb
    begin
        case (op_t'(op_reg))
            OP_SET: op_tag = TAG_SET;
            OP_CLR: op_tag = TAG_CLR;
            default: op_tag = TAG_INV;
        endcase
    end

    // width of node n: SPAN >> floor(log2 n)
    function automatic logic [OW-1:0] width_of(logic [NW-1:0] n);
        logic [OW-1:0] w;
        w = '0;
        for (int k = 0; k < NW; k++)
            if (n[k]) w = OW'(SPAN >> k);
        return w;
    endfunction

    function automatic logic [OW-1:0] effect(logic [OW-1:0] o, logic [OW-1:0] w, tag_t t);
        logic [OW-1:0] res;
        case (t)
            TAG_INV: res = w - o;
            TAG_CLR: res = '0;
            TAG_SET: res = w;
            default: res = o;
        endcase
        return res;
    endfunction

    assign cur_leaf = cmd.sel_hi ? hi_reg : lo_reg;
    assign cur_node = cur_leaf >> h_reg;
    assign kid_lo = {cur_node[NW-2:0], 1'b0};
    assign kid_hi = {cur_node[NW-2:0], 1'b1};

    // range walk moves: left end steps past a taken odd node, right end past an even one
    assign l_up = {1'b0, l_reg} + {{NW{1'b0}}, l_reg[0]};
    assign r_dn = r_reg - {{(NW-1){1'b0}}, ~r_reg[0]};

    // registered memory reads
    always_ff @(posedge clk)
    begin
        rd_a <= ones_mem[ra_a];
        rd_b <= ones_mem[ra_b];
        rd_tag <= tag_mem[ra_t];
        if (we_o) ones_mem[wa_o] <= wd_o;
        if (we_t) tag_mem[wa_t] <= wd_t;
    end

    // step logic
    always_comb
    begin
        clr_next = clr_reg;
        clearing_next = clearing_reg;
        op_next = op_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        l_next = l_reg;
        r_next = r_reg;
        h_next = h_reg;
        sub_next = sub_reg;
        bit_next = bit_reg;
        skip_next = skip_reg;
        total_next = total_reg;
        ptag_next = ptag_reg;
        ra_a = '0;
        ra_b = '0;
        ra_t = '0;
        we_o = 1'b0;
        wa_o = '0;
        wd_o = '0;
        we_t = 1'b0;
        wa_t = '0;
        wd_t = TAG_NONE;
        done_c = 1'b0;
        lvl_step = 1'b0;

        if (clearing_reg)
        begin
            we_o = 1'b1;
            wa_o = clr_reg;
            wd_o = '0;
            we_t = 1'b1;
            wa_t = clr_reg[NW-2:0];
            wd_t = TAG_NONE;
            if (clr_reg == NW'(2*SPAN - 1)) clearing_next = 1'b0;
            else clr_next = clr_reg + 1'b1;
        end
        else if (cmd.start)
        begin
            op_next = operation;
            lo_next = lo_start;
            hi_next = hi_start;
            l_next = lo_start;
            r_next = hi_start;
            bit_next = leaf_bit;
            total_next = '0;
            h_next = LVW'(LEV);
            sub_next = '0;
            if (operation > OP_W'(OP_COUNT)) skip_next = 1'b1;
            else if (operation == OP_W'(OP_LOAD))
                skip_next = (a_ext >= AW'(LEAVES));
            else skip_next = (a_ext >= AW'(LEAVES)) || (a_ext > b_cl);
        end
        else
        begin
            case (cmd.phase)
                // push tags down from root towards the leaf
                PH_PUSH:
                begin
                    if (!skip_reg)
                    begin
                        case (sub_reg)
                            2'd0:
                            begin
                                ra_t = cur_node[NW-2:0];
                                ra_a = kid_lo;
                                ra_b = kid_hi;
                                sub_next = 2'd1;
                            end
                            2'd1:
                            begin
                                if (rd_tag == TAG_NONE) lvl_step = 1'b1;
                                else
                                begin
                                    ptag_next = rd_tag;
                                    we_o = 1'b1;
                                    wa_o = kid_lo;
                                    wd_o = effect(rd_a, width_of(kid_lo), rd_tag);
                                    we_t = 1'b1;
                                    wa_t = cur_node[NW-2:0];
                                    wd_t = TAG_NONE;
                                    ra_b = kid_hi;
                                    ra_t = kid_lo[NW-2:0];
                                    sub_next = 2'd2;
                                end
                            end
                            2'd2:
                            begin
                                we_o = 1'b1;
                                wa_o = kid_hi;
                                wd_o = effect(rd_b, width_of(kid_hi), ptag_reg);
                                if (h_reg != LVW'(1))
                                begin
                                    we_t = 1'b1;
                                    wa_t = kid_lo[NW-2:0];
                                    wd_t = tag_compose(rd_tag, ptag_reg);
                                end
                                ra_t = kid_hi[NW-2:0];
                                sub_next = 2'd3;
                            end
                            default:
                            begin
                                if (h_reg != LVW'(1))
                                begin
                                    we_t = 1'b1;
                                    wa_t = kid_hi[NW-2:0];
                                    wd_t = tag_compose(rd_tag, ptag_reg);
                                end
                                lvl_step = 1'b1;
                            end
                        endcase
                        if (lvl_step)
                        begin
                            sub_next = 2'd0;
                            if (h_reg == LVW'(1))
                            begin
                                done_c = 1'b1;
                                h_next = LVW'(LEV);
                            end
                            else h_next = h_reg - 1'b1;
                        end
                    end
                end
                PH_LOAD:
                begin
                    we_o = 1'b1;
                    wa_o = lo_reg;
                    wd_o = OW'(bit_reg);
                    h_next = LVW'(1);
                end
                // range walk: each level handles the left node then the right node
                PH_WALK:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            if (l_reg > r_reg)
                            begin
                                done_c = 1'b1;
                                h_next = LVW'(1);
                            end
                            else
                            begin
                                ra_a = l_reg;
                                ra_b = r_reg;
                                ra_t = l_reg[NW-2:0];
                                sub_next = 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            ra_b = r_reg;
                            ra_t = r_reg[NW-2:0];
                            if (l_reg[0])
                            begin
                                if (cnt_op) total_next = total_reg + SUMW'(rd_a);
                                else
                                begin
                                    we_o = 1'b1;
                                    wa_o = l_reg;
                                    wd_o = effect(rd_a, width_of(l_reg), op_tag);
                                    if (!l_reg[NW-1])
                                    begin
                                        we_t = 1'b1;
                                        wa_t = l_reg[NW-2:0];
                                        wd_t = tag_compose(rd_tag, op_tag);
                                    end
                                end
                            end
                            sub_next = 2'd2;
                        end
                        default:
                        begin
                            if (!r_reg[0])
                            begin
                                if (cnt_op) total_next = total_reg + SUMW'(rd_b);
                                else
                                begin
                                    we_o = 1'b1;
                                    wa_o = r_reg;
                                    wd_o = effect(rd_b, width_of(r_reg), op_tag);
                                    if (!r_reg[NW-1])
                                    begin
                                        we_t = 1'b1;
                                        wa_t = r_reg[NW-2:0];
                                        wd_t = tag_compose(rd_tag, op_tag);
                                    end
                                end
                            end
                            l_next = l_up[NW:1];
                            r_next = r_dn >> 1;
                            sub_next = 2'd0;
                        end
                    endcase
                end
                PH_FIX:
                begin
                    ra_t = cur_node[NW-2:0];
                    ra_a = {cur_node[NW-2:0], 1'b0};
                    ra_b = {cur_node[NW-2:0], 1'b1};
                    if (sub_reg == 2'd0) sub_next = 2'd1;
                    else
                    begin
                        sub_next = 2'd0;
                        we_o = 1'b1;
                        wa_o = cur_node;
                        wd_o = effect(rd_a + rd_b, width_of(cur_node), rd_tag);
                        if (h_reg == LVW'(LEV))
                        begin
                            done_c = 1'b1;
                            h_next = LVW'(1);
                        end
                        else h_next = h_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.step_done = done_c;
    assign stat.skip = skip_reg && (cmd.phase == PH_PUSH);
    assign stat.is_count = cnt_op;
    assign stat.is_load = (op_reg == OP_W'(OP_LOAD));
    assign stat.clearing = clearing_reg;
    assign ones_count = CNT_W'(total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            clearing_reg <= 1'b1;
            h_reg <= '0;
            sub_reg <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            clr_reg <= clr_next;
            clearing_reg <= clearing_next;
            h_reg <= h_next;
            sub_reg <= sub_next;
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        l_reg <= l_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
        total_reg <= total_next;
        ptag_reg <= ptag_next;
    end
endmodule
